FILE: hdl/vsr_pkg.sv
// ----------------------------------------------------------------------------
// Voigt stress rotation package
// Shared constants and types for the stress rotation pipeline.
// ----------------------------------------------------------------------------
package vsr_pkg;

   localparam int CFG_BITS = 48;
   localparam int CFG_IDX_BITS = 3;
   localparam int NUM_CFG = 6;
   localparam int ENTRY_BITS = 16;
   localparam int R_BITS = 21;
   localparam int BOND_BITS = 34;

   localparam logic [CFG_IDX_BITS-1:0] REG_FROM_ROW0 = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_FROM_ROW1 = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_FROM_ROW2 = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_TO_ROW0 = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_TO_ROW1 = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_TO_ROW2 = 3'd5;

   localparam logic [CFG_BITS-1:0] ROW0_RESET = 48'h0000_0000_4000;
   localparam logic [CFG_BITS-1:0] ROW1_RESET = 48'h0000_4000_0000;
   localparam logic [CFG_BITS-1:0] ROW2_RESET = 48'h4000_0000_0000;

   typedef logic signed [BOND_BITS-1:0] bond_type [6][6];

endpackage

FILE: hdl/voigt_stress_rotation_core.sv
// ----------------------------------------------------------------------------
// Voigt stress rotation core
// Rotates a Voigt stress vector between two configured bases.
// The item pipeline has three register stages: products, sums with rounding,
// and the saturated result.
// Throughput is one item per cycle through the product pipeline while the result channel does not stall.
// Reset is synchronous and restores both bases to identity.
// After a basis write, the Bond matrix settles through the R, product and Bond registers.
// ----------------------------------------------------------------------------
module voigt_stress_rotation_core #(
   parameter int STRESS_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [vsr_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [vsr_pkg::CFG_BITS-1:0]         csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [STRESS_BITS-1:0]        req_s_xx,
   input  logic signed [STRESS_BITS-1:0]        req_s_yy,
   input  logic signed [STRESS_BITS-1:0]        req_s_zz,
   input  logic signed [STRESS_BITS-1:0]        req_s_yz,
   input  logic signed [STRESS_BITS-1:0]        req_s_xz,
   input  logic signed [STRESS_BITS-1:0]        req_s_xy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [STRESS_BITS-1:0]        rsp_t_xx,
   output logic signed [STRESS_BITS-1:0]        rsp_t_yy,
   output logic signed [STRESS_BITS-1:0]        rsp_t_zz,
   output logic signed [STRESS_BITS-1:0]        rsp_t_yz,
   output logic signed [STRESS_BITS-1:0]        rsp_t_xz,
   output logic signed [STRESS_BITS-1:0]        rsp_t_xy,
   output logic                                 rsp_saturated
);
   import vsr_pkg::*;

   logic [CFG_BITS-1:0] from_ff [3];
   logic [CFG_BITS-1:0] to_ff [3];
   bond_type bond;
   logic signed [STRESS_BITS-1:0] s [6];
   logic signed [STRESS_BITS-1:0] t [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         from_ff[0] <= ROW0_RESET;
         from_ff[1] <= ROW1_RESET;
         from_ff[2] <= ROW2_RESET;
         to_ff[0] <= ROW0_RESET;
         to_ff[1] <= ROW1_RESET;
         to_ff[2] <= ROW2_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FROM_ROW0: from_ff[0] <= csr_data;
            REG_FROM_ROW1: from_ff[1] <= csr_data;
            REG_FROM_ROW2: from_ff[2] <= csr_data;
            REG_TO_ROW0:   to_ff[0] <= csr_data;
            REG_TO_ROW1:   to_ff[1] <= csr_data;
            REG_TO_ROW2:   to_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   vsr_bond u_bond (
      .clock    (clock),
      .from_row (from_ff),
      .to_row   (to_ff),
      .bond     (bond)
   );

   assign s[0] = req_s_xx;
   assign s[1] = req_s_yy;
   assign s[2] = req_s_zz;
   assign s[3] = req_s_yz;
   assign s[4] = req_s_xz;
   assign s[5] = req_s_xy;

   vsr_mac_pipe #(.STRESS_BITS(STRESS_BITS)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .bond      (bond),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_s      (s),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_t     (t),
      .out_sat   (rsp_saturated)
   );

   assign rsp_t_xx = t[0];
   assign rsp_t_yy = t[1];
   assign rsp_t_zz = t[2];
   assign rsp_t_yz = t[3];
   assign rsp_t_xz = t[4];
   assign rsp_t_xy = t[5];
endmodule

FILE: hdl/vsr_bond.sv
// ----------------------------------------------------------------------------
// Bond matrix builder
// Forms R from the two bases and the 6x6 Bond matrix from R, outside the item
// pipeline. The user must change bases only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module vsr_bond (
   input  logic                          clock,
   input  logic [vsr_pkg::CFG_BITS-1:0]  from_row [3],
   input  logic [vsr_pkg::CFG_BITS-1:0]  to_row [3],
   output vsr_pkg::bond_type             bond
);
   import vsr_pkg::*;

   logic signed [R_BITS-1:0] r_ff [3][3];
   logic signed [R_BITS-1:0] r_in [3][3];
   logic signed [2*R_BITS:0] p_ff [6][6];
   logic signed [2*R_BITS:0] p_in [6][6];
   bond_type bond_ff;
   bond_type bond_in;

   function automatic logic signed [ENTRY_BITS-1:0] entry(
      input logic [CFG_BITS-1:0] row, input int j);
      entry = row[16*j +: 16];
   endfunction

   always_comb begin
      logic signed [34:0] acc;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
               acc = acc + 35'(entry(to_row[k], i) * entry(from_row[k], j));
            end
            acc = acc + 35'sd2048;
            r_in[i][j] = R_BITS'(acc >>> 12);
         end
      end
   end

   always_comb begin
      int p, q;
      for (int i = 0; i < 6; i++) begin
         p = (i < 3) ? i : ((i == 3) ? 1 : 0);
         q = (i < 3) ? i : ((i == 5) ? 1 : 2);
         p_in[i][0] = (2*R_BITS+1)'(r_ff[p][0] * r_ff[q][0]);
         p_in[i][1] = (2*R_BITS+1)'(r_ff[p][1] * r_ff[q][1]);
         p_in[i][2] = (2*R_BITS+1)'(r_ff[p][2] * r_ff[q][2]);
         p_in[i][3] = (2*R_BITS+1)'(r_ff[p][1] * r_ff[q][2])
                    + (2*R_BITS+1)'(r_ff[p][2] * r_ff[q][1]);
         p_in[i][4] = (2*R_BITS+1)'(r_ff[p][0] * r_ff[q][2])
                    + (2*R_BITS+1)'(r_ff[p][2] * r_ff[q][0]);
         p_in[i][5] = (2*R_BITS+1)'(r_ff[p][0] * r_ff[q][1])
                    + (2*R_BITS+1)'(r_ff[p][1] * r_ff[q][0]);
      end
   end

   always_comb begin
      logic signed [2*R_BITS:0] t;
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 6; j++) begin
            t = p_ff[i][j] + (2*R_BITS+1)'(128);
            bond_in[i][j] = BOND_BITS'(t >>> 8);
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      p_ff <= p_in;
      bond_ff <= bond_in;
   end

   assign bond = bond_ff;
endmodule

FILE: hdl/vsr_mac_pipe.sv
// ----------------------------------------------------------------------------
// Bond product pipeline
// Multiplies the Bond matrix by the stress vector in three stages: products,
// sums with rounding, saturation. A stall freezes every stage.
// ----------------------------------------------------------------------------
module vsr_mac_pipe #(
   parameter int STRESS_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vsr_pkg::bond_type             bond,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic signed [STRESS_BITS-1:0] in_s [6],
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic signed [STRESS_BITS-1:0] out_t [6],
   output logic                          out_sat
);
   import vsr_pkg::*;

   localparam int PW = BOND_BITS + STRESS_BITS;
   localparam int SW = PW + 3;

   logic [2:0] valid_ff;
   logic [2:0] valid_in;
   logic advance;
   logic signed [PW-1:0] prod_ff [6][6];
   logic signed [PW-1:0] prod_in [6][6];
   logic signed [SW-1:0] sum_ff [6];
   logic signed [SW-1:0] sum_in [6];
   logic signed [STRESS_BITS-1:0] t_ff [6];
   logic signed [STRESS_BITS-1:0] t_in [6];
   logic sat_ff;
   logic sat_in;

   assign advance = !(valid_ff[2] && out_stall);
   assign in_stall = !advance;
   assign valid_in = {valid_ff[1:0], in_valid};

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 6; j++) begin
            prod_in[i][j] = PW'(bond[i][j] * in_s[j]);
         end
      end
   end

   always_comb begin
      logic signed [SW-1:0] acc;
      for (int i = 0; i < 6; i++) begin
         acc = SW'(25'sh80_0000);
         for (int j = 0; j < 6; j++) begin
            acc = acc + SW'(prod_ff[i][j]);
         end
         sum_in[i] = acc >>> 24;
      end
   end

   always_comb begin
      logic signed [SW-1:0] mx;
      logic signed [SW-1:0] mn;
      mx = SW'({1'b0, {(STRESS_BITS-1){1'b1}}});
      mn = -mx - SW'(1);
      sat_in = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (sum_ff[i] > mx) begin
            t_in[i] = STRESS_BITS'(mx);
            sat_in = 1'b1;
         end else if (sum_ff[i] < mn) begin
            t_in[i] = STRESS_BITS'(mn);
            sat_in = 1'b1;
         end else begin
            t_in[i] = STRESS_BITS'(sum_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         sum_ff <= sum_in;
         t_ff <= t_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_t = t_ff;
   assign out_sat = sat_ff;
endmodule

FILE: sim/vsr_stress_checker.sv
// ----------------------------------------------------------------------------
// Voigt stress rotation checker
// Watches the register port and both item channels of the rotation core,
// predicts each rotated stress from its own copy of the two bases and
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vsr_stress_checker #(
   parameter int STRESS_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [vsr_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [vsr_pkg::CFG_BITS-1:0]         csr_data,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [STRESS_BITS-1:0]        req_s_xx,
   input  logic signed [STRESS_BITS-1:0]        req_s_yy,
   input  logic signed [STRESS_BITS-1:0]        req_s_zz,
   input  logic signed [STRESS_BITS-1:0]        req_s_yz,
   input  logic signed [STRESS_BITS-1:0]        req_s_xz,
   input  logic signed [STRESS_BITS-1:0]        req_s_xy,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_xx,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_yy,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_zz,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_yz,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_xz,
   input  logic signed [STRESS_BITS-1:0]        rsp_t_xy,
   input  logic                                 rsp_saturated,
   output int                                   mismatches,
   output int                                   outstanding
);

   typedef struct packed {
      logic [5:0][STRESS_BITS-1:0] comp;
      logic                        sat;
   } rotated_stress_type;

   typedef longint stress_vec_type [6];

   localparam longint STRESS_MAX = (longint'(1) <<< (STRESS_BITS - 1)) - 1;
   localparam longint STRESS_MIN = -STRESS_MAX - 1;

   logic [vsr_pkg::CFG_BITS-1:0] basis [vsr_pkg::NUM_CFG];
   rotated_stress_type           rotated_queue [$];
   string                        comp_names [6] = '{"t_xx", "t_yy", "t_zz", "t_yz",
                                                    "t_xz", "t_xy"};

   function automatic longint basis_entry(input logic [vsr_pkg::CFG_BITS-1:0] row,
                                          input int col);
      return longint'($signed(row[16*col +: 16]));
   endfunction

   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic rotated_stress_type rotate_stress(input stress_vec_type s);
      longint             r [3][3];
      longint             b [6][6];
      longint             acc, hi, lo, sh, sl, v;
      int                 p, q;
      rotated_stress_type res;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
               acc += basis_entry(basis[3 + k], i) * basis_entry(basis[k], j);
            end
            r[i][j] = round_shift(acc, 12);
         end
      end
      for (int i = 0; i < 3; i++) begin
         b[i][0] = r[i][0] * r[i][0];
         b[i][1] = r[i][1] * r[i][1];
         b[i][2] = r[i][2] * r[i][2];
         b[i][3] = 2 * r[i][1] * r[i][2];
         b[i][4] = 2 * r[i][0] * r[i][2];
         b[i][5] = 2 * r[i][0] * r[i][1];
      end
      for (int i = 3; i < 6; i++) begin
         p = (i == 3) ? 1 : 0;
         q = (i == 5) ? 1 : 2;
         b[i][0] = r[p][0] * r[q][0];
         b[i][1] = r[p][1] * r[q][1];
         b[i][2] = r[p][2] * r[q][2];
         b[i][3] = r[p][1] * r[q][2] + r[p][2] * r[q][1];
         b[i][4] = r[p][0] * r[q][2] + r[p][2] * r[q][0];
         b[i][5] = r[p][0] * r[q][1] + r[p][1] * r[q][0];
      end
      res.sat = 1'b0;
      for (int i = 0; i < 6; i++) begin
         hi = 0;
         lo = 0;
         for (int j = 0; j < 6; j++) begin
            sh = s[j] >>> 24;
            sl = s[j] - (sh <<< 24);
            hi += round_shift(b[i][j], 8) * sh;
            lo += round_shift(b[i][j], 8) * sl;
         end
         v = hi + round_shift(lo, 24);
         if (v > STRESS_MAX) begin
            v = STRESS_MAX;
            res.sat = 1'b1;
         end else if (v < STRESS_MIN) begin
            v = STRESS_MIN;
            res.sat = 1'b1;
         end
         res.comp[i] = v[STRESS_BITS-1:0];
      end
      return res;
   endfunction

   assign outstanding = rotated_queue.size();

   always @(posedge clock) begin
      stress_vec_type     s;
      rotated_stress_type want, got;
      if (reset) begin
         basis[vsr_pkg::REG_FROM_ROW0] <= vsr_pkg::ROW0_RESET;
         basis[vsr_pkg::REG_FROM_ROW1] <= vsr_pkg::ROW1_RESET;
         basis[vsr_pkg::REG_FROM_ROW2] <= vsr_pkg::ROW2_RESET;
         basis[vsr_pkg::REG_TO_ROW0] <= vsr_pkg::ROW0_RESET;
         basis[vsr_pkg::REG_TO_ROW1] <= vsr_pkg::ROW1_RESET;
         basis[vsr_pkg::REG_TO_ROW2] <= vsr_pkg::ROW2_RESET;
         rotated_queue.delete();
         mismatches <= 0;
      end else begin
         if (csr_write && csr_index < vsr_pkg::NUM_CFG) begin
            basis[csr_index] <= csr_data;
         end
         if (req_valid && !req_stall) begin
            s = '{longint'(req_s_xx), longint'(req_s_yy), longint'(req_s_zz),
                  longint'(req_s_yz), longint'(req_s_xz), longint'(req_s_xy)};
            rotated_queue.push_back(rotate_stress(s));
         end
         if (rsp_valid && !rsp_stall) begin
            got.comp = {rsp_t_xy, rsp_t_xz, rsp_t_yz, rsp_t_zz, rsp_t_yy, rsp_t_xx};
            got.sat = rsp_saturated;
            if (rotated_queue.size() == 0) begin
               if (mismatches < 10) begin
                  $display("Result item arrived with no item outstanding.");
               end
               mismatches <= mismatches + 1;
            end else begin
               want = rotated_queue.pop_front();
               if (want != got) begin
                  if (mismatches < 10) begin
                     for (int i = 0; i < 6; i++) begin
                        if (want.comp[i] != got.comp[i]) begin
                           $display("Mismatch on %s: expected %0d, got %0d.", comp_names[i],
                                    $signed(want.comp[i]), $signed(got.comp[i]));
                        end
                     end
                     if (want.sat != got.sat) begin
                        $display("Mismatch on saturated: expected %0b, got %0b.",
                                 want.sat, got.sat);
                     end
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

FILE: sim/tb_voigt_stress_rotation_core.sv
// ----------------------------------------------------------------------------
// Voigt stress rotation core testbench
// Drives stress items through the core under several basis settings, with
// random idling on both channels and one long result hold-off, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_voigt_stress_rotation_core;

   localparam int SB = 32;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef logic [SB-1:0] stress_item_type [6];

   logic                             clock;
   logic                             reset;
   logic                             csr_write;
   logic [vsr_pkg::CFG_IDX_BITS-1:0] csr_index;
   logic [vsr_pkg::CFG_BITS-1:0]     csr_data;
   logic                             req_valid;
   logic                             req_stall;
   logic signed [SB-1:0]             req_s_xx, req_s_yy, req_s_zz;
   logic signed [SB-1:0]             req_s_yz, req_s_xz, req_s_xy;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [SB-1:0]             rsp_t_xx, rsp_t_yy, rsp_t_zz;
   logic signed [SB-1:0]             rsp_t_yz, rsp_t_xz, rsp_t_xy;
   logic                             rsp_saturated;
   int                               mismatches;
   int                               outstanding;
   int                               quiet_cycles;
   int                               hold_left;
   bit                               calm;
   bit                               long_hold_request;
   bit                               long_hold_done;

   voigt_stress_rotation_core #(.STRESS_BITS(SB)) uut (.*);

   vsr_stress_checker #(.STRESS_BITS(SB)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_request && !long_hold_done) begin
         hold_left <= 40;
         long_hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold_left <= $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("voigt_stress_rotation_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [vsr_pkg::CFG_BITS-1:0] pack_row(input logic [15:0] e0,
                                                               input logic [15:0] e1,
                                                               input logic [15:0] e2);
      return {e2, e1, e0};
   endfunction

   function automatic logic [SB-1:0] random_stress();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(SB-1){1'b1}}};
         1: return {1'b1, {(SB-1){1'b0}}};
         2, 3: return SB'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [vsr_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [vsr_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      repeat (5) @(negedge clock);
   endtask

   task automatic load_bases(input logic [vsr_pkg::CFG_BITS-1:0] f0, f1, f2, t0, t1, t2);
      settle();
      write_reg(vsr_pkg::REG_FROM_ROW0, f0);
      write_reg(vsr_pkg::REG_FROM_ROW1, f1);
      write_reg(vsr_pkg::REG_FROM_ROW2, f2);
      write_reg(vsr_pkg::REG_TO_ROW0, t0);
      write_reg(vsr_pkg::REG_TO_ROW1, t1);
      write_reg(vsr_pkg::REG_TO_ROW2, t2);
   endtask

   task automatic send_stress(input stress_item_type s);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      {req_s_xx, req_s_yy, req_s_zz} <= {s[0], s[1], s[2]};
      {req_s_yz, req_s_xz, req_s_xy} <= {s[3], s[4], s[5]};
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random(input int count);
      stress_item_type s;
      repeat (count) begin
         foreach (s[i]) s[i] = random_stress();
         send_stress(s);
      end
   endtask

   task automatic send_directed();
      stress_item_type s;
      s = '{default: '0};
      send_stress(s);
      s = '{default: {1'b0, {(SB-1){1'b1}}}};
      send_stress(s);
      s = '{default: {1'b1, {(SB-1){1'b0}}}};
      send_stress(s);
      s = '{default: '1};
      send_stress(s);
      s = '{SB'(32'h5555_5555), SB'(32'hAAAA_AAAA), SB'(32'h5555_5555),
            SB'(32'hAAAA_AAAA), SB'(32'h5555_5555), SB'(32'hAAAA_AAAA)};
      send_stress(s);
      for (int f = 0; f < 6; f++) begin
         s = '{default: '0};
         s[f] = SB'(1 << 16);
         send_stress(s);
         s[f] = {1'b1, {(SB-1){1'b0}}};
         send_stress(s);
      end
   endtask

   initial begin
      logic [vsr_pkg::CFG_BITS-1:0] rnd [6];
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      {req_s_xx, req_s_yy, req_s_zz, req_s_yz, req_s_xz, req_s_xy} = '0;
      calm = 1'b0;
      long_hold_request = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send_directed();
      send_random(120);

      // Largest positive entries: a strongly non-orthonormal basis that saturates.
      load_bases(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF), pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                 pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF), pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                 pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF), pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
      write_reg(vsr_pkg::CFG_IDX_BITS'(vsr_pkg::NUM_CFG), '0);
      write_reg(vsr_pkg::CFG_IDX_BITS'(vsr_pkg::NUM_CFG + 1), '1);
      send_directed();
      send_random(120);

      load_bases('1, '1, '1, {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000},
                 {16'h8000, 16'h8000, 16'h8000});
      send_random(120);

      // Rotation by the 3-4-5 angle about z, against a plain identity target.
      load_bases(pack_row(16'd9830, 16'd13107, 16'd0), pack_row(-16'sd13107, 16'd9830, 16'd0),
                 vsr_pkg::ROW2_RESET, vsr_pkg::ROW0_RESET, vsr_pkg::ROW1_RESET,
                 vsr_pkg::ROW2_RESET);
      long_hold_request = 1'b1;
      send_random(150);

      for (int phase = 0; phase < 2; phase++) begin
         foreach (rnd[i]) rnd[i] = vsr_pkg::CFG_BITS'({$urandom, $urandom});
         load_bases(rnd[0], rnd[1], rnd[2], rnd[3], rnd[4], rnd[5]);
         send_random(120);
      end

      load_bases('0, '0, '0, '0, '0, '0);
      send_random(60);

      load_bases(pack_row(16'd0, 16'd16384, 16'd0), pack_row(16'd0, 16'd0, 16'd16384),
                 vsr_pkg::ROW0_RESET, vsr_pkg::ROW0_RESET, vsr_pkg::ROW1_RESET,
                 vsr_pkg::ROW2_RESET);
      calm = 1'b1;
      send_random(150);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("voigt_stress_rotation_core regression: pass");
      end else begin
         $display("voigt_stress_rotation_core regression: fail");
      end
      $finish;
   end

endmodule
